[sv/pts_pkg.sv]
// Package for the periodic task scheduler core.
// Holds action and outcome codes and default sizes; no dependencies.
package pts_pkg;

	localparam int MAX_TASKS_DEF    = 16;
	localparam int ENABLE_LEVEL_DEF = 255;

	// at most this many fired results per tick
	localparam int RESULT_LIMIT = 16;

	localparam int ACTION_W  = 3;
	localparam int INDEX_W   = 8;
	localparam int PERIOD_W  = 32;
	localparam int STATUS_W  = 16;
	localparam int TIME_W    = 32;
	localparam int TASK_W    = 4;
	localparam int VALUE_W   = 32;
	localparam int OUTCOME_W = 2;

	localparam logic [ACTION_W-1:0] ACT_TICK        = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_CREATE      = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_SET_STATUS  = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_SET_PERIOD  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_READ_STATUS = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_READ_PERIOD = 3'd5;

	localparam logic [OUTCOME_W-1:0] OUT_OK      = 2'd0;
	localparam logic [OUTCOME_W-1:0] OUT_NO_TASK = 2'd1;
	localparam logic [OUTCOME_W-1:0] OUT_FULL    = 2'd2;
	localparam logic [OUTCOME_W-1:0] OUT_QUIET   = 2'd3;

endpackage

[sv/pts_req_if.sv]
// Request channel of the periodic task scheduler core.
// Depends on pts_pkg for field widths.
interface pts_req_if import pts_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [INDEX_W-1:0]  task_index;
	logic [PERIOD_W-1:0] period_value;
	logic [STATUS_W-1:0] status_value;
	logic [TIME_W-1:0]   now_ms;

	modport source (output valid, action, task_index, period_value, status_value, now_ms,
		input ready);
	modport sink (input valid, action, task_index, period_value, status_value, now_ms,
		output ready);
endinterface

[sv/pts_rsp_if.sv]
// Result channel of the periodic task scheduler core.
// Depends on pts_pkg for field widths.
interface pts_rsp_if import pts_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [TASK_W-1:0]    result_task;
	logic [VALUE_W-1:0]   read_value;
	logic [OUTCOME_W-1:0] outcome;
	logic                 last;

	modport source (output valid, result_task, read_value, outcome, last, input ready);
	modport sink (input valid, result_task, read_value, outcome, last, output ready);
endinterface

[sv/periodic_task_scheduler_core.sv]
// Create, set and read: the request is accepted in idle, then the response loads
// in ST_RESP once the output register is free. A tick checks one table entry per
// cycle with the single elapsed-time subtract and compare, holding while a fired
// result waits for the output register to drain, stops early once RESULT_LIMIT tasks have fired, then flushes.
// One request at a time. Reset clears the sequencer, output valid and the task
// count; the tables hold nothing until a create writes an entry.
module periodic_task_scheduler_core import pts_pkg::*; #(
	parameter int MAX_TASKS    = MAX_TASKS_DEF,
	parameter int ENABLE_LEVEL = ENABLE_LEVEL_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	pts_req_if.sink   req,
	pts_rsp_if.source rsp
);

	localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int FW = $clog2(RESULT_LIMIT + 1);
	localparam logic [STATUS_W-1:0] EN_LEVEL = STATUS_W'(ENABLE_LEVEL);
	localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_TASKS);
	localparam logic [FW-1:0] FIRE_MAX = FW'(RESULT_LIMIT);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_FLUSH = 4'b0100,
		ST_RESP  = 4'b1000
	} state_t;

	state_t state_q;

	logic [PERIOD_W-1:0] period_mem [MAX_TASKS];
	logic [STATUS_W-1:0] status_mem [MAX_TASKS];
	logic [TIME_W-1:0]   start_mem  [MAX_TASKS];

	logic [PERIOD_W-1:0] rd_period_q;
	logic [STATUS_W-1:0] rd_status_q;
	logic [TIME_W-1:0]   rd_start_q;

	logic [CW-1:0]        count_q;
	logic [AW-1:0]        idx_q;
	logic [FW-1:0]        fired_q;
	logic                 pend_valid_q;
	logic [TASK_W-1:0]    pend_task_q;
	logic [TIME_W-1:0]    now_q;
	logic [ACTION_W-1:0]  op_q;
	logic                 ok_q;
	logic [TASK_W-1:0]    task_q;
	logic [OUTCOME_W-1:0] code_q;

	logic                 out_valid_q;
	logic [TASK_W-1:0]    out_task_q;
	logic [VALUE_W-1:0]   out_value_q;
	logic [OUTCOME_W-1:0] out_code_q;
	logic                 out_last_q;

	logic                 accept;
	logic                 can_load;
	logic                 out_load;
	logic                 idx_ok;
	logic                 full;
	logic [TIME_W-1:0]    elapsed;
	logic                 fire;
	logic                 step_go;
	logic                 done;
	logic [CW-1:0]        idx_nx;
	logic [INDEX_W-1:0]   idx_wide;
	logic [AW-1:0]        rd_addr;

	logic                per_we;
	logic [AW-1:0]       per_wa;
	logic [PERIOD_W-1:0] per_wd;
	logic                sta_we;
	logic [AW-1:0]       sta_wa;
	logic [STATUS_W-1:0] sta_wd;
	logic                stt_we;
	logic [AW-1:0]       stt_wa;
	logic [TIME_W-1:0]   stt_wd;

	assign req.ready       = (state_q == ST_IDLE);
	assign accept          = req.valid & req.ready;
	assign can_load        = ~out_valid_q | rsp.ready;
	assign idx_ok          = req.task_index < INDEX_W'(count_q);
	assign full            = (count_q == COUNT_MAX);
	assign idx_nx          = CW'(idx_q) + CW'(1);
	assign idx_wide        = INDEX_W'(idx_q);

	// shared unit: elapsed time against period, one entry per cycle unless step_go holds
	assign elapsed = now_q - rd_start_q;
	assign fire    = (rd_status_q != '0) && (rd_status_q <= EN_LEVEL) &&
		(elapsed > rd_period_q);
	// hold when a fire would push out the pending result and the output is busy
	assign step_go = ~fire | ~pend_valid_q | can_load;
	assign done    = (idx_nx == count_q) || (fire && (fired_q + FW'(1) == FIRE_MAX));

	assign out_load = ((state_q == ST_SCAN) && step_go && fire && pend_valid_q) ||
		(((state_q == ST_FLUSH) || (state_q == ST_RESP)) && can_load);

	always_comb begin
		per_we = 1'b0;
		per_wa = req.task_index[AW-1:0];
		per_wd = req.period_value;
		sta_we = 1'b0;
		sta_wa = req.task_index[AW-1:0];
		sta_wd = req.status_value;
		stt_we = 1'b0;
		stt_wa = count_q[AW-1:0];
		stt_wd = req.now_ms;
		rd_addr = idx_q;
		case (state_q)
			ST_IDLE: begin
				rd_addr = (req.action == ACT_TICK) ? '0 : req.task_index[AW-1:0];
				if (accept) begin
					case (req.action)
						ACT_CREATE: begin
							if (!full) begin
								per_we = 1'b1;
								per_wa = count_q[AW-1:0];
								sta_we = 1'b1;
								sta_wa = count_q[AW-1:0];
								stt_we = 1'b1;
							end
						end
						ACT_SET_STATUS: sta_we = idx_ok;
						ACT_SET_PERIOD: per_we = idx_ok;
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				if (step_go && !done)
					rd_addr = idx_nx[AW-1:0];
				if (step_go && fire) begin
					stt_we = 1'b1;
					stt_wa = idx_q;
					stt_wd = now_q;
					sta_we = (rd_status_q < EN_LEVEL);
					sta_wa = idx_q;
					sta_wd = rd_status_q - STATUS_W'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (per_we)
			period_mem[per_wa] <= per_wd;
		rd_period_q <= period_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (sta_we)
			status_mem[sta_wa] <= sta_wd;
		rd_status_q <= status_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (stt_we)
			start_mem[stt_wa] <= stt_wd;
		rd_start_q <= start_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (rsp.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						now_q  <= req.now_ms;
						op_q   <= req.action;
						task_q <= req.task_index[TASK_W-1:0];
						ok_q   <= idx_ok;
						code_q <= idx_ok ? OUT_OK : OUT_NO_TASK;
						// keep the read address until the response loads
						idx_q  <= req.task_index[AW-1:0];
						case (req.action)
							ACT_TICK: begin
								idx_q        <= '0;
								fired_q      <= '0;
								pend_valid_q <= 1'b0;
								state_q      <= (count_q == '0) ? ST_FLUSH : ST_SCAN;
							end
							ACT_CREATE: begin
								if (full) begin
									task_q <= '0;
									code_q <= OUT_FULL;
								end else begin
									task_q  <= TASK_W'(count_q);
									code_q  <= OUT_OK;
									count_q <= count_q + CW'(1);
								end
								state_q <= ST_RESP;
							end
							ACT_SET_STATUS, ACT_SET_PERIOD,
							ACT_READ_STATUS, ACT_READ_PERIOD: state_q <= ST_RESP;
							default: ;  // unused action: drop
						endcase
					end
				end
				ST_SCAN: begin
					if (step_go) begin
						if (fire) begin
							if (pend_valid_q) begin
								out_task_q  <= pend_task_q;
								out_value_q <= '0;
								out_code_q  <= OUT_OK;
								out_last_q  <= 1'b0;
							end
							pend_valid_q <= 1'b1;
							pend_task_q  <= idx_wide[TASK_W-1:0];
							fired_q      <= fired_q + FW'(1);
						end
						if (done)
							state_q <= ST_FLUSH;
						else
							idx_q <= idx_nx[AW-1:0];
					end
				end
				ST_FLUSH: begin
					if (can_load) begin
						out_task_q   <= pend_valid_q ? pend_task_q : '0;
						out_value_q  <= '0;
						out_code_q   <= pend_valid_q ? OUT_OK : OUT_QUIET;
						out_last_q   <= 1'b1;
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				ST_RESP: begin
					if (can_load) begin
						out_task_q  <= task_q;
						out_code_q  <= code_q;
						out_last_q  <= 1'b1;
						if (ok_q && op_q == ACT_READ_STATUS)
							out_value_q <= VALUE_W'(rd_status_q);
						else if (ok_q && op_q == ACT_READ_PERIOD)
							out_value_q <= rd_period_q;
						else
							out_value_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.result_task = out_task_q;
	assign rsp.read_value  = out_value_q;
	assign rsp.outcome     = out_code_q;
	assign rsp.last        = out_last_q;

endmodule

[tb/pts_result_check.sv]
// Result checker for the periodic task scheduler core: watches both channels,
// predicts every result from accepted requests and compares field by field.
// Depends on pts_pkg and the pts_req_if / pts_rsp_if channel interfaces.
module pts_result_check import pts_pkg::*; #(
	parameter int MAX_TASKS    = MAX_TASKS_DEF,
	parameter int ENABLE_LEVEL = ENABLE_LEVEL_DEF
) (
	input  logic clk,
	input  logic arst_n,
	pts_req_if   req,
	pts_rsp_if   rsp,
	output int   errors,
	output int   pending,
	output int   requests,
	output int   firings,
	output int   quiet_ticks,
	output int   full_answers,
	output int   bad_index_answers
);

	typedef struct packed {
		logic [TASK_W-1:0]    task_id;
		logic [VALUE_W-1:0]   value;
		logic [OUTCOME_W-1:0] outcome;
		logic                 last;
	} sched_result_t;

	sched_result_t answers_q[$];

	logic [PERIOD_W-1:0] period_tbl [MAX_TASKS];
	logic [STATUS_W-1:0] status_tbl [MAX_TASKS];
	logic [TIME_W-1:0]   start_tbl  [MAX_TASKS];
	int                  task_total;

	function automatic void push_answer(input logic [TASK_W-1:0] tid,
			input logic [VALUE_W-1:0] value, input logic [OUTCOME_W-1:0] outc,
			input logic fin);
		answers_q.push_back('{task_id: tid, value: value, outcome: outc, last: fin});
	endfunction

	function automatic void predict_tick(input logic [TIME_W-1:0] now);
		int                  fired;
		logic [TIME_W-1:0]   elapsed;
		logic [STATUS_W-1:0] st;
		fired = 0;
		for (int i = 0; i < task_total && i < MAX_TASKS && fired < RESULT_LIMIT; i++) begin
			st = status_tbl[i];
			if (st != '0 && st <= ENABLE_LEVEL) begin
				elapsed = now - start_tbl[i];
				if (elapsed > period_tbl[i]) begin
					start_tbl[i] = now;
					// count down the remaining runs
					if (st < ENABLE_LEVEL)
						status_tbl[i] = st - 1'b1;
					push_answer(TASK_W'(i), '0, OUT_OK, 1'b0);
					fired++;
				end
			end
		end
		if (fired == 0) begin
			push_answer('0, '0, OUT_QUIET, 1'b1);
			quiet_ticks++;
		end else begin
			answers_q[answers_q.size() - 1].last = 1'b1;
			firings += fired;
		end
	endfunction

	function automatic void predict_request(input logic [ACTION_W-1:0] act,
			input logic [INDEX_W-1:0] idx, input logic [PERIOD_W-1:0] per,
			input logic [STATUS_W-1:0] st, input logic [TIME_W-1:0] now);
		logic                 hit;
		logic [OUTCOME_W-1:0] outc;
		logic [VALUE_W-1:0]   value;
		hit   = (idx < task_total) && (idx < MAX_TASKS);
		outc  = hit ? OUT_OK : OUT_NO_TASK;
		value = '0;
		if (!hit && act inside {ACT_SET_STATUS, ACT_SET_PERIOD, ACT_READ_STATUS,
				ACT_READ_PERIOD})
			bad_index_answers++;
		case (act)
			ACT_TICK: begin
				predict_tick(now);
			end
			ACT_CREATE: begin
				if (task_total >= MAX_TASKS) begin
					push_answer('0, '0, OUT_FULL, 1'b1);
					full_answers++;
				end else begin
					period_tbl[task_total] = per;
					status_tbl[task_total] = st;
					start_tbl[task_total]  = now;
					push_answer(TASK_W'(task_total), '0, OUT_OK, 1'b1);
					task_total++;
				end
			end
			ACT_SET_STATUS: begin
				if (hit)
					status_tbl[idx] = st;
				push_answer(idx[TASK_W-1:0], '0, outc, 1'b1);
			end
			ACT_SET_PERIOD: begin
				if (hit)
					period_tbl[idx] = per;
				push_answer(idx[TASK_W-1:0], '0, outc, 1'b1);
			end
			ACT_READ_STATUS: begin
				if (hit)
					value = VALUE_W'(status_tbl[idx]);
				push_answer(idx[TASK_W-1:0], value, outc, 1'b1);
			end
			ACT_READ_PERIOD: begin
				if (hit)
					value = VALUE_W'(period_tbl[idx]);
				push_answer(idx[TASK_W-1:0], value, outc, 1'b1);
			end
			default: begin
				// unused action codes are dropped without a result
			end
		endcase
	endfunction

	function automatic void check_result();
		sched_result_t want;
		if (answers_q.size() == 0) begin
			$error("result with no request waiting: result_task %0d outcome %0d",
				rsp.result_task, rsp.outcome);
			errors++;
			return;
		end
		want = answers_q.pop_front();
		if (rsp.result_task !== want.task_id) begin
			$error("result_task: expected %0d, got %0d", want.task_id, rsp.result_task);
			errors++;
		end
		if (rsp.read_value !== want.value) begin
			$error("read_value: expected 0x%08h, got 0x%08h", want.value, rsp.read_value);
			errors++;
		end
		if (rsp.outcome !== want.outcome) begin
			$error("outcome: expected %0d, got %0d", want.outcome, rsp.outcome);
			errors++;
		end
		if (rsp.last !== want.last) begin
			$error("last: expected %0d, got %0d", want.last, rsp.last);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			answers_q.delete();
			task_total        = 0;
			errors            = 0;
			pending           = 0;
			requests          = 0;
			firings           = 0;
			quiet_ticks       = 0;
			full_answers      = 0;
			bad_index_answers = 0;
		end else begin
			// a result never belongs to the request accepted at the same edge
			if (rsp.valid && rsp.ready)
				check_result();
			if (req.valid && req.ready) begin
				requests++;
				predict_request(req.action, req.task_index, req.period_value,
					req.status_value, req.now_ms);
			end
			pending = answers_q.size();
		end
	end

endmodule

[tb/periodic_task_scheduler_core_tb.sv]
// Top of the periodic task scheduler core testbench: clock, reset, request
// stimulus, output back-pressure and the verdict.
// Depends on pts_pkg, the channel interfaces, the core and pts_result_check.
module periodic_task_scheduler_core_tb;
	import pts_pkg::*;

	localparam int MAX_TASKS     = MAX_TASKS_DEF;
	localparam int ENABLE_LEVEL  = ENABLE_LEVEL_DEF;
	localparam int RANDOM_ITEMS  = 190;
	localparam int PHASE_ITEMS   = 24;
	localparam int HOLD_CYCLES   = 200;
	localparam int DRAIN_CYCLES  = 2 * (MAX_TASKS + 4);
	localparam int LIMIT_CYCLES  = 1_000_000;
	localparam int CLK_PERIOD    = 20;

	localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = ACT_READ_PERIOD + 1'b1;
	localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = '1;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	const idle_mode_t phase_plan [8] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
		IDLE_NONE, IDLE_RECV, IDLE_SEND, IDLE_BOTH};

	logic clk = 1'b0;
	logic arst_n;

	idle_mode_t        idle_mode;
	logic              hold_kick;
	logic              hold_used = 1'b0;
	int                hold_left = 0;
	int                n_created;
	logic [TIME_W-1:0] ms_now;

	int errors, pending, requests, firings, quiet_ticks, full_answers, bad_index_answers;

	pts_req_if req();
	pts_rsp_if rsp();

	periodic_task_scheduler_core #(
		.MAX_TASKS    (MAX_TASKS),
		.ENABLE_LEVEL (ENABLE_LEVEL)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	pts_result_check #(
		.MAX_TASKS    (MAX_TASKS),
		.ENABLE_LEVEL (ENABLE_LEVEL)
	) result_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.req               (req),
		.rsp               (rsp),
		.errors            (errors),
		.pending           (pending),
		.requests          (requests),
		.firings           (firings),
		.quiet_ticks       (quiet_ticks),
		.full_answers      (full_answers),
		.bad_index_answers (bad_index_answers)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic bit sender_idles();
		return (idle_mode == IDLE_SEND && $urandom_range(99) < 74) ||
			(idle_mode == IDLE_BOTH && $urandom_range(99) < 35);
	endfunction

	function automatic bit receiver_stalls();
		return (idle_mode == IDLE_RECV && $urandom_range(99) < 74) ||
			(idle_mode == IDLE_BOTH && $urandom_range(99) < 35);
	endfunction

	// long output hold-off, started once by the stimulus
	always @(posedge clk) begin
		if (hold_kick && !hold_used) begin
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		rsp.ready <= arst_n && hold_left == 0 && !receiver_stalls();
	end

	task automatic send_request(input logic [ACTION_W-1:0] act, input logic [INDEX_W-1:0] idx,
			input logic [PERIOD_W-1:0] per, input logic [STATUS_W-1:0] st,
			input logic [TIME_W-1:0] now);
		if (sender_idles()) begin
			req.valid <= 1'b0;
			do @(posedge clk); while (sender_idles());
		end
		req.valid        <= 1'b1;
		req.action       <= act;
		req.task_index   <= idx;
		req.period_value <= per;
		req.status_value <= st;
		req.now_ms       <= now;
		do @(posedge clk); while (!req.ready);
		if (act == ACT_CREATE && n_created < MAX_TASKS)
			n_created++;
	endtask

	task automatic tick_at(input logic [TIME_W-1:0] now);
		send_request(ACT_TICK, INDEX_W'($urandom), $urandom, STATUS_W'($urandom), now);
	endtask

	function automatic logic [PERIOD_W-1:0] pick_period();
		if ($urandom_range(7) == 0)
			return $urandom;
		return $urandom_range(0, 40);
	endfunction

	function automatic logic [STATUS_W-1:0] pick_status();
		int roll;
		roll = $urandom_range(99);
		if (roll < 40)
			return STATUS_W'($urandom_range(1, 5));
		if (roll < 55)
			return STATUS_W'($urandom_range(6, ENABLE_LEVEL - 1));
		if (roll < 80)
			return STATUS_W'(ENABLE_LEVEL);
		if (roll < 90)
			return '0;
		return STATUS_W'($urandom);
	endfunction

	function automatic logic [INDEX_W-1:0] pick_index();
		if (n_created == 0 || $urandom_range(99) < 15)
			return INDEX_W'($urandom);
		return INDEX_W'($urandom_range(0, n_created - 1));
	endfunction

	function automatic logic [ACTION_W-1:0] ACT_ACTION_PICK();
		return ACTION_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
	endfunction

	initial begin
		int made;
		int roll;
		req.valid        = 1'b0;
		req.action       = ACT_TICK;
		req.task_index   = '0;
		req.period_value = '0;
		req.status_value = '0;
		req.now_ms       = '0;
		hold_kick        = 1'b0;
		idle_mode        = IDLE_NONE;
		n_created        = 0;
		arst_n           = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, firing rules, wrap of the elapsed time, bad indexes
		send_request(ACT_READ_STATUS, 8'd0, $urandom, STATUS_W'($urandom), $urandom);
		tick_at(32'd0);
		send_request(ACT_CREATE, INDEX_W'($urandom), 32'd0, STATUS_W'(ENABLE_LEVEL), 32'd1000);
		tick_at(32'd1000);
		tick_at(32'd1001);
		send_request(ACT_CREATE, INDEX_W'($urandom), 32'd5, 16'd2, 32'd1001);
		tick_at(32'd1007);
		tick_at(32'd1013);
		tick_at(32'd1020);
		send_request(ACT_CREATE, INDEX_W'($urandom), '1, 16'd1, 32'hFFFF_FFF0);
		send_request(ACT_CREATE, INDEX_W'($urandom), 32'd10, STATUS_W'(ENABLE_LEVEL + 1), 32'd0);
		send_request(ACT_CREATE, INDEX_W'($urandom), 32'd3, 16'd100, 32'hFFFF_FFFE);
		tick_at(32'd5);
		send_request(ACT_SET_STATUS, 8'd1, $urandom, STATUS_W'(ENABLE_LEVEL), $urandom);
		send_request(ACT_SET_PERIOD, 8'd1, 32'h8000_0000, STATUS_W'($urandom), $urandom);
		send_request(ACT_READ_STATUS, 8'd1, $urandom, STATUS_W'($urandom), $urandom);
		send_request(ACT_READ_PERIOD, 8'd1, $urandom, STATUS_W'($urandom), $urandom);
		send_request(ACT_SET_STATUS, 8'd200, $urandom, 16'd7, $urandom);
		send_request(ACT_SET_PERIOD, 8'd5, 32'd9, STATUS_W'($urandom), $urandom);
		send_request(ACT_READ_PERIOD, '1, $urandom, STATUS_W'($urandom), $urandom);
		send_request(ACT_READ_STATUS, 8'd16, $urandom, STATUS_W'($urandom), $urandom);
		send_request(ACT_UNUSED_LO, 8'd0, $urandom, STATUS_W'($urandom), $urandom);
		send_request(ACT_UNUSED_HI, 8'd1, $urandom, STATUS_W'($urandom), $urandom);
		send_request(ACT_SET_STATUS, 8'd2, $urandom, '1, $urandom);
		send_request(ACT_READ_STATUS, 8'd2, $urandom, STATUS_W'($urandom), $urandom);

		// random: ticks most often, on a moving clock, mixed with creates, sets, reads and unused actions
		ms_now = 32'd5;
		made   = 0;
		while (made < RANDOM_ITEMS) begin
			idle_mode <= phase_plan[(made / PHASE_ITEMS) % $size(phase_plan)];
			if (made == 110)
				hold_kick <= 1'b1;
			roll = $urandom_range(99);
			if (roll < 3) begin
				send_request(ACT_ACTION_PICK(), INDEX_W'($urandom), $urandom,
					STATUS_W'($urandom), $urandom);
			end else begin
				if (roll < 15) begin
					send_request(ACT_CREATE, INDEX_W'($urandom), pick_period(), pick_status(),
						ms_now);
				end else if (roll < 58) begin
					ms_now += $urandom_range(0, 25);
					// jump the clock now and then, backward or across the wrap
					if ($urandom_range(15) == 0)
						ms_now = $urandom;
					tick_at(ms_now);
				end else if (roll < 70) begin
					send_request(ACT_SET_STATUS, pick_index(), $urandom, pick_status(), $urandom);
				end else if (roll < 80) begin
					send_request(ACT_SET_PERIOD, pick_index(), pick_period(),
						STATUS_W'($urandom), $urandom);
				end else if (roll < 90) begin
					send_request(ACT_READ_STATUS, pick_index(), $urandom, STATUS_W'($urandom),
						$urandom);
				end else begin
					send_request(ACT_READ_PERIOD, pick_index(), $urandom, STATUS_W'($urandom),
						$urandom);
				end
				made++;
			end
		end

		// fill the table and go one past it
		repeat (MAX_TASKS - n_created + 1)
			send_request(ACT_CREATE, INDEX_W'($urandom), pick_period(), pick_status(), ms_now);
		req.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pending != 0)
			$error("%0d expected results never arrived", pending);
		$display("Covered %0d requests: %0d task firings, %0d quiet ticks, %0d table-full",
			requests, firings, quiet_ticks, full_answers);
		$display("and %0d bad-index answers, over four idling patterns and a long output stall.",
			bad_index_answers);
		if (errors == 0 && pending == 0) begin
			$display("** periodic_task_scheduler_core: PASSED **");
		end else begin
			$display("** periodic_task_scheduler_core: FAILED **");
		end
		$finish;
	end

	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("** periodic_task_scheduler_core: FAILED **");
		$finish;
	end

endmodule
